// File: design/cdss_pkg.sv
// ----------------------------------------------------------------------------
// Spring smoother package
// Shared types, widths, operation codes and decay tables.
// ----------------------------------------------------------------------------
package cdss_pkg;

	localparam int CHANNEL_COUNT_DEF = 15;
	localparam int CH_W = 4;
	localparam int VAL_W = 32;
	localparam int PACE_W = 16;
	localparam int DT_W = 16;
	localparam int WIDE_W = 48;

	typedef enum logic [1:0] {
		OP_STEP      = 2'd0,
		OP_SET_PACE  = 2'd1,
		OP_SET_OVR   = 2'd2,
		OP_CLR_OVR   = 2'd3
	} op_t;

	// One channel's stored record.
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] velocity;
		logic [PACE_W-1:0] pace;
		logic signed [VAL_W-1:0] ovr;
		logic ovr_valid;
	} chan_rec_t;

	function automatic logic [16:0] frac_tab(input logic [4:0] i);
		logic [16:0] r;
		begin
			unique case (i)
				5'd0: r = 17'd65536; 5'd1: r = 17'd61565; 5'd2: r = 17'd57835;
				5'd3: r = 17'd54331; 5'd4: r = 17'd51039; 5'd5: r = 17'd47947;
				5'd6: r = 17'd45042; 5'd7: r = 17'd42313; 5'd8: r = 17'd39750;
				5'd9: r = 17'd37341; 5'd10: r = 17'd35079; 5'd11: r = 17'd32953;
				5'd12: r = 17'd30957; 5'd13: r = 17'd29081; 5'd14: r = 17'd27319;
				5'd15: r = 17'd25664; 5'd16: r = 17'd24109;
				default: r = 17'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [16:0] int_tab(input logic [3:0] n);
		logic [16:0] r;
		begin
			unique case (n)
				4'd0: r = 17'd65536; 4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
				4'd3: r = 17'd3263; 4'd4: r = 17'd1200; 4'd5: r = 17'd442;
				4'd6: r = 17'd162; 4'd7: r = 17'd60; 4'd8: r = 17'd22;
				4'd9: r = 17'd8; 4'd10: r = 17'd3; 4'd11: r = 17'd1;
				default: r = 17'd0;
			endcase
			return r;
		end
	endfunction

	// Saturate a signed 96-bit value to 48 bits.
	function automatic logic signed [WIDE_W-1:0] sat48(input logic signed [95:0] x);
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		begin
			hi = 96'sd140737488355327;
			lo = -96'sd140737488355328;
			if (x > hi) return hi[WIDE_W-1:0];
			else if (x < lo) return lo[WIDE_W-1:0];
			else return x[WIDE_W-1:0];
		end
	endfunction

	// Saturate a signed 96-bit value to 32 bits.
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [95:0] x);
		begin
			if (x > 96'sd2147483647) return 32'sh7fffffff;
			else if (x < -96'sd2147483648) return 32'sh80000000;
			else return x[VAL_W-1:0];
		end
	endfunction

endpackage

// File: design/critically_damped_spring_smoother_top.sv
// ----------------------------------------------------------------------------
// Critically damped spring smoother
// Multi-channel fixed-point spring smoother built on a channel record memory.
// ----------------------------------------------------------------------------
// An in-range step with a nonzero time passes ST_READ, ST_CALC, ST_WRIT and
// ST_OUT in that order; every other request skips ST_CALC.
// One request at a time: the memory read, a sequenced chain of products on one
// datapath and the write-back are done before the next request is accepted,
// and a stalled output holds ST_OUT until out_ready.
// Reset: asynchronous, all channel records read as zero and no result pending.
module critically_damped_spring_smoother_top #(
	parameter int CHANNEL_COUNT = cdss_pkg::CHANNEL_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] operation,
	input  logic [cdss_pkg::CH_W-1:0] channel,
	input  logic signed [31:0] target_value,
	input  logic [15:0] elapsed_time,
	input  logic [15:0] pace_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [cdss_pkg::CH_W-1:0] result_channel,
	output logic signed [31:0] current_value,
	output logic signed [31:0] current_velocity
);
	localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_CALC = 5'b00100,
		ST_WRIT = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;
	cdss_pkg::op_t op_q;
	logic [cdss_pkg::CH_W-1:0] ch_q;
	logic signed [31:0] tgt_q;
	logic [15:0] dt_q;
	logic [15:0] pin_q;
	logic in_range_q;
	cdss_pkg::chan_rec_t rec_q;
	cdss_pkg::chan_rec_t rd_data;
	cdss_pkg::chan_rec_t wr_rec;
	logic wr_en;
	logic [AW-1:0] addr;
	logic [AW-1:0] rd_addr;

	// Datapath registers.
	logic signed [47:0] x0_q, c2_q, wc2_q, pos_q, vel_q;
	logic signed [31:0] t_q;
	logic [16:0] e_q, fv_q;
	logic [31:0] a_q;
	logic signed [31:0] res_val_q, res_vel_q;

	assign addr = AW'(ch_q);

	// The read is issued with the accepting edge so the record is ready in ST_READ.
	assign rd_addr = in_ready ? AW'(channel) : addr;

	cdss_mem #(.CHANNEL_COUNT(CHANNEL_COUNT), .AW(AW)) u_mem (
		.clk(clk), .arst_n(arst_n), .rd_addr(rd_addr), .rd_data(rd_data),
		.wr_en(wr_en), .wr_addr(addr), .wr_data(wr_rec)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign result_channel = ch_q;
	assign current_value = res_val_q;
	assign current_velocity = res_vel_q;
	assign wr_en = (state_q == ST_WRIT) && in_range_q;

	// Record to write back, per operation.
	always_comb begin
		wr_rec = rec_q;
		unique case (op_q)
			cdss_pkg::OP_STEP: begin
				if (dt_q != 16'd0) begin
					wr_rec.value = res_val_q;
					wr_rec.velocity = res_vel_q;
				end
			end
			cdss_pkg::OP_SET_PACE: wr_rec.pace = pin_q;
			cdss_pkg::OP_SET_OVR: begin
				wr_rec.ovr = tgt_q;
				wr_rec.ovr_valid = 1'b1;
			end
			cdss_pkg::OP_CLR_OVR: wr_rec.ovr_valid = 1'b0;
			default: wr_rec = rec_q;
		endcase
	end

	// Sequencer and the shared product chain, a few products per step.
	logic signed [48:0] wq;
	logic signed [48:0] dtq;
	logic [3:0] n_w;
	logic [4:0] idx_w;
	logic [16:0] lo_w, stp_w;
	always_comb begin
		wq = {33'd0, rec_q.pace};
		dtq = {33'd0, dt_q};
		n_w = a_q[31:28] == 4'd0 ? a_q[27:24] : 4'd15;
		idx_w = {1'b0, a_q[23:20]};
		lo_w = cdss_pkg::frac_tab(idx_w);
		stp_w = lo_w - cdss_pkg::frac_tab(idx_w + 5'd1);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= cdss_pkg::op_t'(operation);
			ch_q <= channel;
			tgt_q <= target_value;
			dt_q <= elapsed_time;
			pin_q <= pace_value;
			in_range_q <= ({28'd0, channel} < CHANNEL_COUNT);
		end
		if (state_q == ST_READ) begin
			rec_q <= rd_data;
			res_val_q <= in_range_q ? rd_data.value : '0;
			res_vel_q <= in_range_q ? rd_data.velocity : '0;
			t_q <= rd_data.ovr_valid ? rd_data.ovr : tgt_q;
		end
		if (state_q == ST_CALC) begin
			unique case (step_q)
				4'd0: begin
					a_q <= rec_q.pace * dt_q;
					x0_q <= 48'(rec_q.value) - 48'(t_q);
				end
				4'd1: begin
					fv_q <= lo_w - 17'((({47'd0, stp_w} * {44'd0, a_q[19:0]})) >> 20);
					c2_q <= cdss_pkg::sat48(96'(rec_q.velocity)
						+ ((96'(wq) * 96'(x0_q)) >>> 8));
				end
				4'd2: begin
					e_q <= (n_w >= 4'd12) ? 17'd0 : 17'((({17'd0, cdss_pkg::int_tab(n_w)}
						* {17'd0, fv_q}) + 34'd32768) >> 16);
					pos_q <= cdss_pkg::sat48(96'(x0_q) + ((96'(c2_q) * 96'(dtq)) >>> 16));
				end
				4'd3: begin
					wc2_q <= cdss_pkg::sat48((96'(wq) * 96'(c2_q)) >>> 8);
					res_val_q <= cdss_pkg::sat32(((96'(pos_q)
						* 96'($signed({1'b0, e_q}))) >>> 16) + 96'(t_q));
				end
				4'd4: begin
					vel_q <= cdss_pkg::sat48(96'(rec_q.velocity)
						- ((96'(wc2_q) * 96'(dtq)) >>> 16));
				end
				default: begin
					res_vel_q <= cdss_pkg::sat32((96'(vel_q)
						* 96'($signed({1'b0, e_q}))) >>> 16);
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					step_q <= '0;
					state_q <= (op_q == cdss_pkg::OP_STEP && dt_q != 16'd0 && in_range_q)
						? ST_CALC : ST_WRIT;
				end
				ST_CALC: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5) begin
						state_q <= ST_WRIT;
					end
				end
				ST_WRIT: state_q <= ST_OUT;
				ST_OUT: if (out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks.
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_nowr_oor: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> in_range_q) else $error("write to out-of-range channel");
	a_out_after_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_WRIT) else $error("result without write-back");
endmodule

// File: design/cdss_mem.sv
// ----------------------------------------------------------------------------
// Spring smoother channel memory
// Synchronous channel record store with a registered read and per-entry valid bits.
// ----------------------------------------------------------------------------
module cdss_mem #(
	parameter int CHANNEL_COUNT = cdss_pkg::CHANNEL_COUNT_DEF,
	parameter int AW = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [AW-1:0] rd_addr,
	output cdss_pkg::chan_rec_t rd_data,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cdss_pkg::chan_rec_t wr_data
);
	cdss_pkg::chan_rec_t mem [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] written_q;
	cdss_pkg::chan_rec_t raw_q;
	logic raw_ok_q;

	// Write port and written flags; an unwritten entry reads as zero.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			raw_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			raw_ok_q <= written_q[rd_addr];
		end
	end

	assign rd_data = raw_ok_q ? raw_q : '0;
endmodule

// File: tb/sv/critically_damped_spring_smoother_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spring smoother testbench
// Drives random and directed requests through the valid/ready handshake and
// checks every result against a fixed-point prediction of the spring.
// ----------------------------------------------------------------------------
module critically_damped_spring_smoother_top_tb;

	localparam int NCH = 15;

	typedef struct packed {
		logic [3:0] ch;
		logic signed [31:0] value;
		logic signed [31:0] velocity;
	} spring_result_t;

	// Scoreboard: keeps the predicted channel state and the queue of pending results.
	class spring_scoreboard;
		logic signed [31:0] value_mem[NCH];
		logic signed [31:0] vel_mem[NCH];
		logic [15:0] pace_mem[NCH];
		logic signed [31:0] ovr_mem[NCH];
		bit ovr_on[NCH];
		spring_result_t pending_results[$];
		int mismatches;

		function new();
			for (int i = 0; i < NCH; i++) begin
				value_mem[i] = 0;
				vel_mem[i] = 0;
				pace_mem[i] = 0;
				ovr_mem[i] = 0;
				ovr_on[i] = 0;
			end
			mismatches = 0;
		endfunction

		function longint floor_shr(longint x, int n);
			return x >>> n;
		endfunction

		function longint clamp(longint x, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (x > hi) return hi;
			if (x < lo) return lo;
			return x;
		endfunction

		function longint frac_entry(int i);
			int t[17] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
				39750, 37341, 35079, 32953, 30957, 29081, 27319, 25664, 24109};
			return t[i];
		endfunction

		// Decay factor exp(-pace*dt/2^24) in units of 2^-16.
		function longint decay(longint w, longint dt);
			int it[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
			longint a;
			longint n;
			longint fr;
			longint idx;
			longint rem;
			longint lo;
			longint fv;
			a = w * dt;
			n = a >> 24;
			fr = a & 64'hFFFFFF;
			idx = fr >> 20;
			rem = fr & 64'hFFFFF;
			if (n >= 12) return 0;
			lo = frac_entry(idx);
			fv = lo - (((lo - frac_entry(idx + 1)) * rem) >> 20);
			return (it[n] * fv + 32768) >> 16;
		endfunction

		// Note an accepted request: update the predicted state and queue the result.
		function void note_request(logic [1:0] op, logic [3:0] ch, logic signed [31:0] tgt_in,
			logic [15:0] dt, logic [15:0] pace);
			spring_result_t r;
			longint tgt;
			longint v;
			longint v0;
			longint w;
			longint e;
			longint x0;
			longint c2;
			longint wc2;
			longint pos;
			longint vel;
			r.ch = ch;
			r.value = 0;
			r.velocity = 0;
			if (ch < NCH) begin
				case (cdss_pkg::op_t'(op))
					cdss_pkg::OP_STEP: begin
						if (dt != 0) begin
							tgt = ovr_on[ch] ? longint'(ovr_mem[ch]) : longint'(tgt_in);
							v = value_mem[ch];
							v0 = vel_mem[ch];
							w = pace_mem[ch];
							e = decay(w, dt);
							x0 = v - tgt;
							c2 = clamp(v0 + floor_shr(w * x0, 8), 48);
							pos = clamp(x0 + floor_shr(c2 * dt, 16), 48);
							pos = clamp(floor_shr(pos * e, 16) + tgt, 32);
							wc2 = clamp(floor_shr(w * c2, 8), 48);
							vel = clamp(v0 - floor_shr(wc2 * dt, 16), 48);
							vel = clamp(floor_shr(vel * e, 16), 32);
							value_mem[ch] = pos;
							vel_mem[ch] = vel;
						end
					end
					cdss_pkg::OP_SET_PACE: pace_mem[ch] = pace;
					cdss_pkg::OP_SET_OVR: begin
						ovr_mem[ch] = tgt_in;
						ovr_on[ch] = 1;
					end
					default: ovr_on[ch] = 0;
				endcase
				r.value = value_mem[ch];
				r.velocity = vel_mem[ch];
			end
			pending_results.insert(pending_results.size(), r);
		endfunction

		// Compare one result with the oldest pending one.
		function void check_result(spring_result_t got);
			spring_result_t exp_r;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result ch=%0d value=%0d velocity=%0d",
						got.ch, got.value, got.velocity);
				return;
			end
			exp_r = pending_results.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected ch=%0d val=%0d vel=%0d, %s",
						exp_r.ch, exp_r.value, exp_r.velocity,
						$sformatf("got ch=%0d val=%0d vel=%0d", got.ch, got.value,
						got.velocity));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] operation;
	logic [3:0] channel;
	logic signed [31:0] target_value;
	logic [15:0] elapsed_time;
	logic [15:0] pace_value;
	logic out_valid;
	logic out_ready;
	logic [3:0] result_channel;
	logic signed [31:0] current_value;
	logic signed [31:0] current_velocity;

	spring_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	bit stimulus_done;

	critically_damped_spring_smoother_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.channel(channel),
		.target_value(target_value),
		.elapsed_time(elapsed_time),
		.pace_value(pace_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_channel(result_channel),
		.current_value(current_value),
		.current_velocity(current_velocity)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_request(operation, channel, target_value, elapsed_time, pace_value);
		if (arst_n && out_valid && out_ready)
			board.check_result({result_channel, current_value, current_velocity});
	end

	// Receiver stalls at random, changed at the falling edge.
	always @(negedge clk) begin
		if (stimulus_done) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one request, with an optional random gap, and wait for acceptance.
	// Valid stays high after acceptance until the next gap or the next request.
	task automatic send_request(logic [1:0] op, logic [3:0] ch, logic [31:0] tgt,
		logic [15:0] dt, logic [15:0] pace);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		target_value <= tgt;
		elapsed_time <= dt;
		pace_value <= pace;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_target();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h000fffff) - 32'h00080000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_dt();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hffff;
			2: return $urandom_range(16'h0800);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_pace();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hffff;
			2: return $urandom_range(16'h0a00);
			default: return $urandom;
		endcase
	endfunction

	// Random phase: mostly steps on valid channels, some setup ops and bad channels.
	task automatic random_phase(int count);
		logic [1:0] op;
		logic [3:0] ch;
		for (int i = 0; i < count; i++) begin
			ch = ($urandom_range(19) == 0) ? 4'd15 : 4'($urandom_range(NCH - 1));
			case ($urandom_range(9))
				0, 1: op = cdss_pkg::OP_SET_PACE;
				2: op = cdss_pkg::OP_SET_OVR;
				3: op = cdss_pkg::OP_CLR_OVR;
				default: op = cdss_pkg::OP_STEP;
			endcase
			send_request(op, ch, rand_target(), rand_dt(), rand_pace());
		end
	endtask

	initial begin
		board = new();
		stimulus_done = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		operation = cdss_pkg::OP_STEP;
		channel = 0;
		target_value = 0;
		elapsed_time = 0;
		pace_value = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: zero pace drift, extremes, zero time, overrides, bad channel.
		send_request(cdss_pkg::OP_STEP, 4'd0, 32'h7fffffff, 16'hffff, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd0, 32'h00010000, 16'd0, 16'd0);
		send_request(cdss_pkg::OP_SET_PACE, 4'd0, 32'd0, 16'd0, 16'h0400);
		send_request(cdss_pkg::OP_STEP, 4'd0, 32'h7fffffff, 16'hffff, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd0, 32'h80000000, 16'h1000, 16'd0);
		send_request(cdss_pkg::OP_SET_PACE, 4'd1, 32'd0, 16'd0, 16'hffff);
		send_request(cdss_pkg::OP_STEP, 4'd1, 32'h80000000, 16'hffff, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd1, 32'h7fffffff, 16'h0001, 16'd0);
		send_request(cdss_pkg::OP_SET_OVR, 4'd14, 32'h80000000, 16'd0, 16'd0);
		send_request(cdss_pkg::OP_SET_PACE, 4'd14, 32'd0, 16'd0, 16'h0100);
		send_request(cdss_pkg::OP_STEP, 4'd14, 32'h7fffffff, 16'h8000, 16'd0);
		send_request(cdss_pkg::OP_CLR_OVR, 4'd14, 32'd0, 16'd0, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd14, 32'h7fffffff, 16'h8000, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd15, 32'h12345678, 16'h1234, 16'hffff);
		send_request(cdss_pkg::OP_SET_PACE, 4'd15, 32'hffffffff, 16'hffff, 16'hffff);
		send_request(cdss_pkg::OP_SET_PACE, 4'd2, 32'd0, 16'd0, 16'h0c00);
		send_request(cdss_pkg::OP_STEP, 4'd2, 32'h00050000, 16'hffff, 16'd0);
		send_request(cdss_pkg::OP_SET_PACE, 4'd3, 32'd0, 16'd0, 16'h00ff);
		send_request(cdss_pkg::OP_STEP, 4'd3, 32'hfffb0000, 16'h5555, 16'd0);
		send_request(cdss_pkg::OP_STEP, 4'd3, 32'h00000000, 16'haaaa, 16'd0);

		send_idle_pct = 16;
		recv_idle_pct = 68;
		random_phase(245);
		send_idle_pct = 68;
		recv_idle_pct = 16;
		random_phase(245);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(245);

		in_valid <= 1'b0;
		stimulus_done = 1;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
